FILE: sv/psgseq_pkg.sv
// psgseq_pkg: shared types, codes and constants of the event sequencer
`timescale 1ns / 1ps

package psgseq_pkg;

	// payload widths of the two channels
	localparam int FUNC_W    = 3;
	localparam int IN_ADDR_W = 12;
	localparam int BYTE_W    = 8;
	localparam int SRC_W     = 2;

	// command codes
	typedef enum logic [FUNC_W-1:0] {
		FN_LOAD        = 3'd0,
		FN_PLAY_MUSIC  = 3'd1,
		FN_STOP_MUSIC  = 3'd2,
		FN_PLAY_EFFECT = 3'd3,
		FN_TICK        = 3'd4
	} func_t;

	// origin of a register write
	typedef enum logic [SRC_W-1:0] {
		SRC_MUSIC  = 2'd0,
		SRC_EFFECT = 2'd1,
		SRC_STOP   = 2'd2
	} src_t;

	// sound chip registers touched directly
	localparam logic [BYTE_W-1:0] REG_MIXER = 8'd7;
	localparam logic [BYTE_W-1:0] REG_AMP_A = 8'd8;
	localparam logic [BYTE_W-1:0] REG_AMP_B = 8'd9;
	localparam logic [BYTE_W-1:0] REG_AMP_C = 8'd10;

	// mixer handling
	localparam logic [BYTE_W-1:0] MIXER_RESET = 8'h3F;
	localparam logic [BYTE_W-1:0] MIXER_KEEP  = 8'hDB;
	localparam logic [BYTE_W-1:0] MIXER_TAKE  = 8'h24;
	localparam logic [BYTE_W-1:0] MIXER_BIT6  = 8'h40;
	localparam logic [BYTE_W-1:0] VAL_ZERO    = 8'h00;

	// special write counts in an event
	localparam logic [BYTE_W-1:0] CNT_END  = 8'h00;
	localparam logic [BYTE_W-1:0] CNT_LOOP = 8'hFF;

	// one register write
	typedef struct packed {
		logic [BYTE_W-1:0] reg_num;
		logic [BYTE_W-1:0] value;
		logic [SRC_W-1:0]  src;
	} emit_t;

	// request from the sequencer to the result queue
	typedef struct packed {
		logic  valid;
		logic  fin;
		emit_t data;
	} push_t;

	// one delivered result
	typedef struct packed {
		emit_t wr;
		logic  last;
	} res_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADV,
		ST_CNT,
		ST_PREG,
		ST_PVAL,
		ST_WLD,
		ST_OFF_LO,
		ST_OFF_HI,
		ST_STOP,
		ST_EFX_END,
		ST_FIN
	} state_t;

	// mute sequence, one write per step
	function automatic emit_t stop_write(input logic [1:0] idx);
		emit_t e;
		e.src = SRC_STOP;
		unique case (idx)
			2'd0: begin
				e.reg_num = REG_AMP_A;
				e.value   = VAL_ZERO;
			end
			2'd1: begin
				e.reg_num = REG_AMP_B;
				e.value   = VAL_ZERO;
			end
			2'd2: begin
				e.reg_num = REG_AMP_C;
				e.value   = VAL_ZERO;
			end
			default: begin
				e.reg_num = REG_MIXER;
				e.value   = MIXER_RESET;
			end
		endcase
		return e;
	endfunction

endpackage

FILE: sv/psgseq_cmd_if.sv
// psgseq_cmd_if: command channel of the event sequencer
`timescale 1ns / 1ps

interface psgseq_cmd_if;
	import psgseq_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [FUNC_W-1:0]    func;
	logic [IN_ADDR_W-1:0] address;
	logic [BYTE_W-1:0]    load_byte;

	modport source (output valid, output func, output address, output load_byte, input ready);
	modport sink   (input valid, input func, input address, input load_byte, output ready);
endinterface

FILE: sv/psgseq_rsp_if.sv
// psgseq_rsp_if: register write channel of the event sequencer
`timescale 1ns / 1ps

interface psgseq_rsp_if;
	import psgseq_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] psg_register;
	logic [BYTE_W-1:0] psg_value;
	logic [SRC_W-1:0]  write_source;
	logic              last_write;

	modport source (
		output valid, output psg_register, output psg_value,
		output write_source, output last_write, input ready
	);
	modport sink (
		input valid, input psg_register, input psg_value,
		input write_source, input last_write, output ready
	);
endinterface

FILE: sv/psgseq_store.sv
// psgseq_store: event byte store, one write port and one registered read port
`timescale 1ns / 1ps

module psgseq_store #(
	parameter int STORE_BYTES = 4096,
	localparam int AW = $clog2(STORE_BYTES)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [psgseq_pkg::BYTE_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [psgseq_pkg::BYTE_W-1:0] rd_data
);
	import psgseq_pkg::*;

	logic [BYTE_W-1:0] mem [STORE_BYTES];
	logic [BYTE_W-1:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port, data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

FILE: sv/psgseq_outq.sv
// psgseq_outq: result queue that marks the final write of each command
`timescale 1ns / 1ps

module psgseq_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  psgseq_pkg::push_t push,
	output logic              push_ready,
	psgseq_rsp_if.source      rsp
);
	import psgseq_pkg::*;

	logic  pend_v_q;
	emit_t pend_q;
	logic  out_v_q;
	res_t  out_q;
	logic  out_free;
	logic  take;
	logic  move;

	// a write is held back until it is known whether another follows
	assign out_free   = !out_v_q || rsp.ready;
	assign push_ready = !pend_v_q || out_free;
	assign take       = push.valid && push_ready;
	assign move       = take && pend_v_q;

	// held write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (take) begin
			pend_v_q <= !push.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (take && !push.fin) begin
			pend_q <= push.data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (move) begin
			out_v_q <= 1'b1;
		end else if (rsp.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_q.wr   <= pend_q;
			out_q.last <= push.fin;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.psg_register = out_q.wr.reg_num;
	assign rsp.psg_value    = out_q.wr.value;
	assign rsp.write_source = out_q.wr.src;
	assign rsp.last_write   = out_q.last;
endmodule

FILE: sv/psgseq_ctrl.sv
// psgseq_ctrl: command decoder and stream sequencer around the event store
`timescale 1ns / 1ps

module psgseq_ctrl #(
	parameter int STORE_BYTES = 4096,
	parameter int MAX_WRITES  = 16,
	localparam int AW = $clog2(STORE_BYTES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	psgseq_cmd_if.sink                    cmd,
	output logic                          wr_en,
	output logic [AW-1:0]                 wr_addr,
	output logic [psgseq_pkg::BYTE_W-1:0] wr_data,
	output logic                          rd_en,
	output logic [AW-1:0]                 rd_addr,
	input  logic [psgseq_pkg::BYTE_W-1:0] rd_data,
	output psgseq_pkg::push_t             push,
	input  logic                          push_ready
);
	import psgseq_pkg::*;

	localparam int CW = $clog2(MAX_WRITES + 1);
	localparam logic [BYTE_W-1:0] MAX_N = BYTE_W'(MAX_WRITES);

	state_t state_q, state_d;

	// stream state
	logic [AW-1:0]     base_q;
	logic [AW-1:0]     mcur_q;
	logic              playing_q;
	logic [BYTE_W-1:0] mwait_q;
	logic              primed_q;
	logic [AW-1:0]     ecur_q;
	logic              active_q;
	logic [BYTE_W-1:0] ewait_q;
	logic [BYTE_W-1:0] mixer_q;

	// sequencing state
	logic              chan_q;
	logic              stop_ret_q;
	logic [1:0]        idx_q;
	logic [CW-1:0]     cnt_q;
	logic [AW-1:0]     w_q;
	logic [BYTE_W-1:0] reg_q;
	logic [BYTE_W-1:0] off_lo_q;

	logic                   accept;
	logic [AW+IN_ADDR_W-1:0] addr_ext;
	logic [AW-1:0]          cmd_addr;
	logic [AW-1:0]          cur;
	logic [BYTE_W-1:0]      cur_wait;
	logic                   cur_on;
	logic [AW+15:0]         off_ext;
	logic [AW-1:0]          loop_cur;
	logic [AW-1:0]          w_next;
	logic                   fire;
	logic                   pushed;
	emit_t                  raw;
	emit_t                  pair_wr;

	// commands are taken only between transactions
	assign cmd.ready = (state_q == ST_IDLE);

	// command address reduced to the store size
	assign accept   = cmd.valid && cmd.ready;
	assign addr_ext = {{AW{1'b0}}, cmd.address};
	assign cmd_addr = addr_ext[AW-1:0];

	// selected channel
	assign cur      = chan_q ? ecur_q : mcur_q;
	assign cur_wait = chan_q ? ewait_q : mwait_q;
	assign cur_on   = chan_q ? active_q : (playing_q && primed_q);
	assign fire     = cur_on && (cur_wait == '0);
	assign w_next   = w_q + AW'(2);

	// loop target from the low header offset bytes
	assign off_ext  = {{AW{1'b0}}, rd_data, off_lo_q};
	assign loop_cur = base_q + off_ext[AW-1:0];

	// pair write, effect mixer writes take bits 2 and 5 and keep the other shadow bits
	always_comb begin
		pair_wr.reg_num = reg_q;
		pair_wr.value   = rd_data;
		pair_wr.src     = chan_q ? SRC_EFFECT : SRC_MUSIC;
		if (chan_q && (reg_q == REG_MIXER)) begin
			pair_wr.value = (mixer_q & MIXER_KEEP) | (rd_data & MIXER_TAKE);
		end
	end

	assign pushed = push.valid && push_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd.func)
						FN_STOP_MUSIC: state_d = ST_STOP;
						FN_TICK:       state_d = ST_ADV;
						default:       state_d = ST_IDLE;
					endcase
				end
			end
			ST_ADV: begin
				if (fire) begin
					state_d = ST_CNT;
				end else if (chan_q) begin
					state_d = ST_FIN;
				end
			end
			ST_CNT: begin
				if (rd_data == CNT_END) begin
					state_d = chan_q ? ST_EFX_END : ST_STOP;
				end else if (rd_data == CNT_LOOP && !chan_q) begin
					state_d = ST_OFF_LO;
				end else begin
					state_d = ST_PREG;
				end
			end
			ST_PREG:   state_d = ST_PVAL;
			ST_PVAL: begin
				if (push_ready) begin
					state_d = (cnt_q == CW'(1)) ? ST_WLD : ST_PREG;
				end
			end
			ST_WLD:    state_d = chan_q ? ST_FIN : ST_ADV;
			ST_OFF_LO: state_d = ST_OFF_HI;
			ST_OFF_HI: state_d = ST_WLD;
			ST_STOP: begin
				if (push_ready && idx_q == 2'd3) begin
					state_d = stop_ret_q ? ST_ADV : ST_FIN;
				end
			end
			ST_EFX_END: begin
				if (push_ready) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (push_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: store access, result push
	always_comb begin
		wr_en      = accept && (cmd.func == FN_LOAD);
		wr_addr    = cmd_addr;
		wr_data    = cmd.load_byte;
		rd_en      = 1'b0;
		rd_addr    = cur + AW'(1);
		raw        = stop_write(idx_q);
		push.valid = 1'b0;
		push.fin   = 1'b0;
		unique case (state_q)
			ST_ADV: begin
				rd_en   = fire;
				rd_addr = cur + AW'(1);
			end
			ST_CNT: begin
				rd_en   = (rd_data != CNT_END);
				rd_addr = (rd_data == CNT_LOOP && !chan_q) ? base_q + AW'(4) : cur + AW'(2);
			end
			ST_PREG: begin
				rd_en   = 1'b1;
				rd_addr = w_q + AW'(1);
			end
			ST_PVAL: begin
				raw        = pair_wr;
				push.valid = 1'b1;
				rd_en      = push_ready;
				rd_addr    = w_next;
			end
			ST_OFF_LO: begin
				rd_en   = 1'b1;
				rd_addr = base_q + AW'(5);
			end
			ST_OFF_HI: begin
				rd_en   = 1'b1;
				rd_addr = loop_cur;
			end
			ST_STOP: begin
				push.valid = 1'b1;
			end
			ST_EFX_END: begin
				raw.reg_num = REG_AMP_C;
				raw.value   = VAL_ZERO;
				raw.src     = SRC_STOP;
				push.valid  = 1'b1;
			end
			ST_FIN: begin
				push.valid = 1'b1;
				push.fin   = 1'b1;
			end
			default: begin
			end
		endcase
		// every mixer write has bit 6 cleared
		push.data = raw;
		if (raw.reg_num == REG_MIXER) begin
			push.data.value = raw.value & ~MIXER_BIT6;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// stream state and sequencing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q     <= '0;
			mcur_q     <= '0;
			playing_q  <= 1'b0;
			mwait_q    <= '0;
			primed_q   <= 1'b0;
			ecur_q     <= '0;
			active_q   <= 1'b0;
			ewait_q    <= '0;
			mixer_q    <= MIXER_RESET;
			chan_q     <= 1'b0;
			stop_ret_q <= 1'b0;
			idx_q      <= '0;
			cnt_q      <= '0;
			w_q        <= '0;
		end else begin
			// mixer shadow follows every delivered mixer write
			if (pushed && !push.fin && push.data.reg_num == REG_MIXER) begin
				mixer_q <= push.data.value;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (cmd.func)
							FN_PLAY_MUSIC: begin
								if (!(playing_q && base_q == cmd_addr)) begin
									base_q    <= cmd_addr;
									mcur_q    <= cmd_addr + AW'(8);
									playing_q <= 1'b1;
									mwait_q   <= '0;
								end
							end
							FN_STOP_MUSIC: begin
								playing_q  <= 1'b0;
								idx_q      <= '0;
								stop_ret_q <= 1'b0;
							end
							FN_PLAY_EFFECT: begin
								ecur_q   <= cmd_addr + AW'(4);
								active_q <= 1'b1;
								ewait_q  <= '0;
							end
							FN_TICK: chan_q <= 1'b0;
							default: begin
							end
						endcase
					end
				end
				ST_ADV: begin
					if (!chan_q) begin
						if (!playing_q) begin
							chan_q <= 1'b1;
						end else if (!primed_q) begin
							primed_q <= 1'b1;
							chan_q   <= 1'b1;
						end else if (mwait_q != '0) begin
							mwait_q <= mwait_q - 8'd1;
							chan_q  <= 1'b1;
						end
					end else if (active_q && ewait_q != '0) begin
						ewait_q <= ewait_q - 8'd1;
					end
				end
				ST_CNT: begin
					if (rd_data == CNT_END) begin
						if (!chan_q) begin
							playing_q  <= 1'b0;
							idx_q      <= '0;
							stop_ret_q <= 1'b1;
						end
					end else begin
						cnt_q <= (rd_data > MAX_N) ? CW'(MAX_WRITES) : rd_data[CW-1:0];
						w_q   <= cur + AW'(2);
					end
				end
				ST_PVAL: begin
					if (push_ready) begin
						cnt_q <= cnt_q - CW'(1);
						w_q   <= w_next;
						if (cnt_q == CW'(1)) begin
							if (chan_q) begin
								ecur_q <= w_next;
							end else begin
								mcur_q <= w_next;
							end
						end
					end
				end
				ST_WLD: begin
					if (chan_q) begin
						ewait_q <= rd_data;
					end else begin
						mwait_q <= rd_data;
						chan_q  <= 1'b1;
					end
				end
				ST_OFF_HI: mcur_q <= loop_cur;
				ST_STOP: begin
					if (push_ready) begin
						idx_q <= idx_q + 2'd1;
						if (idx_q == 2'd3 && stop_ret_q) begin
							chan_q <= 1'b1;
						end
					end
				end
				ST_EFX_END: begin
					if (push_ready) begin
						active_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// byte latches
	always_ff @(posedge clk) begin
		if (state_q == ST_PREG) begin
			reg_q <= rd_data;
		end
		if (state_q == ST_OFF_LO) begin
			off_lo_q <= rd_data;
		end
	end
endmodule

FILE: sv/psg_event_sequencer.sv
// psg_event_sequencer: top level of the music and effect event sequencer
`timescale 1ns / 1ps

// Plays music and effect event streams out of an internal byte store of
// STORE_BYTES bytes (a power of two) and sends the sound chip register writes
// that fall due on each frame tick. Commands arrive on cmd: load a byte, start
// music, stop music, start an effect, frame tick. A load or play command gives
// no transaction on rsp. A stop gives the four mute writes. A tick walks the
// music cursor, then the effect cursor; every store byte is read through the
// single read port, so a register write reads its register and value bytes.
// Writes leave through a holding stage and an output register, so the last
// write of a command carries last_write; a stall on rsp stalls the sequencer.
// Store bytes must be loaded before a stream reads them.
module psg_event_sequencer #(
	parameter int STORE_BYTES = 4096,
	parameter int MAX_WRITES  = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	psgseq_cmd_if.sink    cmd,
	psgseq_rsp_if.source  rsp
);
	import psgseq_pkg::*;

	localparam int AW = $clog2(STORE_BYTES);

	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	logic [BYTE_W-1:0] wr_data;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic [BYTE_W-1:0] rd_data;
	push_t             push;
	logic              push_ready;

	// event store
	psgseq_store #(
		.STORE_BYTES(STORE_BYTES)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// sequencer
	psgseq_ctrl #(
		.STORE_BYTES(STORE_BYTES),
		.MAX_WRITES (MAX_WRITES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.push      (push),
		.push_ready(push_ready)
	);

	// result queue
	psgseq_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_ready(push_ready),
		.rsp       (rsp)
	);
endmodule
